[rtl/double_hash_table_insert_find_macros.svh]
// Assertion macros for the double hash table block.
// The asserting module provides clock and reset.
`ifndef DOUBLE_HASH_TABLE_INSERT_FIND_MACROS_SVH
`define DOUBLE_HASH_TABLE_INSERT_FIND_MACROS_SVH
`ifndef ASSERT_OFF
`define DHTIF_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`define DHTIF_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define DHTIF_ASSERT_NEVER(label, cond, msg)
`define DHTIF_ASSERT_IMPLIES(label, ante, cons, msg)
`endif
`endif

[rtl/dhtif_pkg.sv]
// Shared constants, codes and controller/datapath interface types.
package dhtif_pkg;

   localparam int MAX_SLOTS    = 1024;
   localparam int SLOT_BITS    = $clog2(MAX_SLOTS);
   localparam int SIZE_BITS    = SLOT_BITS + 1;
   localparam int KEY_BITS     = 32;
   localparam int RECORD_BITS  = 16;
   localparam int KEY_CNT_BITS = $clog2(KEY_BITS);
   localparam int ENTRY_BITS   = 1 + KEY_BITS + RECORD_BITS;
   localparam int CSR_BITS     = 11;
   localparam int MIN_SIZE     = 3;
   localparam logic [CSR_BITS-1:0] CSR_RESET = 11'd1024;

   localparam int REQ_DATA_BITS = KEY_BITS + RECORD_BITS;
   localparam int RSP_DATA_BITS = 32;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_FOUND     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } dhtif_status_type;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_FIND   = 1'b1;

   typedef struct packed {
      logic clear_step;
      logic start;
      logic mod_step;
      logic probe_load;
      logic mem_read;
      logic mem_write;
      logic probe_adv;
      logic out_load;
   } dhtif_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic mod_last;
      logic is_find;
      logic slot_valid;
      logic key_match;
      logic probe_last;
      logic out_free;
   } dhtif_sts_type;

endpackage

[rtl/dhtif_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dhtif_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/dhtif_dp.sv]
// Datapath: size register, remainder unit, probe index, slot RAM and result register.
module dhtif_dp import dhtif_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  dhtif_cmd_type            cmd,
   output dhtif_sts_type            sts,
   input  logic                     csr_we,
   input  logic [CSR_BITS-1:0]      csr_wdata,
   input  logic                     req_type,
   input  logic [REQ_DATA_BITS-1:0] req_data,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [1:0]               rsp_tuser
);

   logic [CSR_BITS-1:0]     size_ff;
   logic [SIZE_BITS-1:0]    used_n;
   logic [SIZE_BITS-1:0]    n_ff;
   logic [SIZE_BITS-1:0]    d2_ff;
   logic [KEY_BITS-1:0]     key_ff;
   logic [KEY_BITS-1:0]     shift_ff;
   logic [RECORD_BITS-1:0]  rec_ff;
   logic                    find_ff;
   logic [KEY_CNT_BITS-1:0] bit_cnt_ff;
   logic [SIZE_BITS-1:0]    rem1_ff;
   logic [SIZE_BITS-1:0]    rem2_ff;
   logic [SIZE_BITS-1:0]    rem1_in;
   logic [SIZE_BITS-1:0]    rem2_in;
   logic [SIZE_BITS:0]      t1;
   logic [SIZE_BITS:0]      t2;
   logic [SLOT_BITS-1:0]    idx_ff;
   logic [SLOT_BITS-1:0]    step_ff;
   logic [SLOT_BITS-1:0]    idx_in;
   logic [SIZE_BITS-1:0]    idx_sum;
   logic [SIZE_BITS-1:0]    probe_cnt_ff;
   logic [SLOT_BITS-1:0]    clear_cnt_ff;

   logic                    wr_en;
   logic [SLOT_BITS-1:0]    wr_addr;
   logic [ENTRY_BITS-1:0]   wr_data;
   logic [ENTRY_BITS-1:0]   rd_data;
   logic                    rd_valid;
   logic [KEY_BITS-1:0]     rd_key;
   logic [RECORD_BITS-1:0]  rd_rec;

   dhtif_status_type        res_status;
   logic [SLOT_BITS-1:0]    res_slot;
   logic [RECORD_BITS-1:0]  res_rec;
   logic                    rsp_valid_ff;
   dhtif_status_type        rsp_status_ff;
   logic [SLOT_BITS-1:0]    rsp_slot_ff;
   logic [RECORD_BITS-1:0]  rsp_rec_ff;

   always_comb begin
      if (int'(size_ff) < MIN_SIZE) begin
         used_n = SIZE_BITS'(MIN_SIZE);
      end else if (int'(size_ff) > MAX_SLOTS) begin
         used_n = SIZE_BITS'(MAX_SLOTS);
      end else begin
         used_n = SIZE_BITS'(size_ff);
      end
   end

   // one key bit per cycle into both remainders
   assign t1 = {rem1_ff, shift_ff[KEY_BITS-1]};
   assign t2 = {rem2_ff, shift_ff[KEY_BITS-1]};
   assign rem1_in = (t1 >= {1'b0, n_ff})  ? SIZE_BITS'(t1 - {1'b0, n_ff})  : SIZE_BITS'(t1);
   assign rem2_in = (t2 >= {1'b0, d2_ff}) ? SIZE_BITS'(t2 - {1'b0, d2_ff}) : SIZE_BITS'(t2);

   assign idx_sum = {1'b0, idx_ff} + {1'b0, step_ff};
   assign idx_in  = (idx_sum >= n_ff) ? SLOT_BITS'(idx_sum - n_ff) : SLOT_BITS'(idx_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= CSR_RESET;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            size_ff <= csr_wdata;
         end
         if (cmd.clear_step) begin
            clear_cnt_ff <= clear_cnt_ff + 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff     <= req_data[KEY_BITS-1:0];
         shift_ff   <= req_data[KEY_BITS-1:0];
         rec_ff     <= req_data[KEY_BITS +: RECORD_BITS];
         find_ff    <= req_type;
         n_ff       <= used_n;
         d2_ff      <= used_n - SIZE_BITS'(2);
         rem1_ff    <= '0;
         rem2_ff    <= '0;
         bit_cnt_ff <= '0;
      end
      if (cmd.mod_step) begin
         shift_ff   <= {shift_ff[KEY_BITS-2:0], 1'b0};
         rem1_ff    <= rem1_in;
         rem2_ff    <= rem2_in;
         bit_cnt_ff <= bit_cnt_ff + 1'b1;
      end
      if (cmd.probe_load) begin
         idx_ff       <= SLOT_BITS'(rem1_ff);
         step_ff      <= SLOT_BITS'(rem2_ff + SIZE_BITS'(1));
         probe_cnt_ff <= '0;
      end
      if (cmd.probe_adv) begin
         idx_ff       <= idx_in;
         probe_cnt_ff <= probe_cnt_ff + 1'b1;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status;
         rsp_slot_ff   <= res_slot;
         rsp_rec_ff    <= res_rec;
      end
   end

   assign wr_en   = cmd.clear_step | cmd.mem_write;
   assign wr_addr = cmd.clear_step ? clear_cnt_ff : idx_ff;
   assign wr_data = cmd.clear_step ? '0 : {1'b1, key_ff, rec_ff};

   dhtif_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(MAX_SLOTS)
   ) u_slots (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (cmd.mem_read),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   assign rd_valid = rd_data[ENTRY_BITS-1];
   assign rd_key   = rd_data[RECORD_BITS +: KEY_BITS];
   assign rd_rec   = rd_data[RECORD_BITS-1:0];

   always_comb begin
      res_slot = '0;
      res_rec  = '0;
      priority if (!find_ff && !rd_valid) begin
         res_status = ST_INSERTED;
         res_slot   = idx_ff;
      end else if (find_ff && rd_valid && rd_key == key_ff) begin
         res_status = ST_FOUND;
         res_slot   = idx_ff;
         res_rec    = rd_rec;
      end else if (find_ff) begin
         res_status = ST_NOT_FOUND;
      end else begin
         res_status = ST_FULL;
      end
   end

   assign sts.clear_last = (clear_cnt_ff == SLOT_BITS'(MAX_SLOTS - 1));
   assign sts.mod_last   = (bit_cnt_ff == KEY_CNT_BITS'(KEY_BITS - 1));
   assign sts.is_find    = find_ff;
   assign sts.slot_valid = rd_valid;
   assign sts.key_match  = (rd_key == key_ff);
   assign sts.probe_last = (probe_cnt_ff == n_ff - SIZE_BITS'(1));
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_rec_ff, rsp_slot_ff});

endmodule

[rtl/dhtif_ctrl.sv]
// Controller: clearing pass, remainder sequencing, probe loop and result handoff.
module dhtif_ctrl import dhtif_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dhtif_sts_type sts,
   output dhtif_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_LOAD,
      S_READ,
      S_CHECK,
      S_POST
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      done;

   assign done = (!sts.is_find && !sts.slot_valid)
              || (sts.is_find && (!sts.slot_valid || sts.key_match))
              || sts.probe_last;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.probe_load = 1'b1;
            state_in       = S_READ;
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            cmd.mem_write = !sts.is_find && !sts.slot_valid;
            if (done) begin
               state_in = S_POST;
            end else begin
               cmd.probe_adv = 1'b1;
               state_in      = S_READ;
            end
         end
         S_POST: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

[rtl/double_hash_table_insert_find.sv]
// Top level of the double hashing insert/find table.
// Open-addressing table of up to 1024 slots probed at (h1 + i*h2) mod size, with
// h1 = key mod size and h2 = 1 + key mod (size - 2). After reset the block runs a
// clearing pass over the slot RAM with req_tready low; the size register can be
// written meanwhile. One word is handled at a time: an insert or find makes 1 to
// size probes before its result is loaded into the result register, and the next
// word is accepted only after that load.
// Both remainders come from one restoring pass that takes one key bit per cycle
// with a subtractor per remainder, the load state then sets up the probe, and each
// probe costs a RAM read and a check.
// A new request is accepted while a finished result still waits on the rsp side.
`include "double_hash_table_insert_find_macros.svh"
module double_hash_table_insert_find import dhtif_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_BITS-1:0]      csr_wdata,      // table_size
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,      // key, record_number
   input  logic                     req_tuser,      // req_type
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,      // slot_index, found_record, zero pad
   output logic [1:0]               rsp_tuser       // status
);

   dhtif_cmd_type cmd;
   dhtif_sts_type sts;

   dhtif_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dhtif_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_type  (req_tuser),
      .req_data  (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   `DHTIF_ASSERT_NEVER(a_wr_collide, cmd.mem_write && cmd.clear_step, "write collision")
   `DHTIF_ASSERT_NEVER(a_out_overrun, cmd.out_load && rsp_tvalid && !rsp_tready, "result overrun")
   `DHTIF_ASSERT_IMPLIES(a_write_full, cmd.mem_write, !sts.slot_valid, "write to used slot")

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the double hashing insert/find table.
module tb_top import dhtif_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          LONG_HOLD_CYCLES = 3000;
   localparam longint      CYCLE_LIMIT      = 8_000_000;

   typedef struct {
      logic        is_find;
      logic [31:0] key;
      logic [15:0] rec;
   } table_req_type;

   typedef struct {
      dhtif_status_type status;
      logic [9:0]       slot;
      logic [15:0]      rec;
   } table_outcome_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     csr_we = 1'b0;
   logic [CSR_BITS-1:0]      csr_wdata = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;   // key, record_number
   logic                     req_tuser = 1'b0; // req_type
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;        // slot_index, found_record, zero pad
   logic [1:0]               rsp_tuser;        // status

   table_req_type      request_queue[$];
   table_outcome_type  pending_outcomes[$];
   logic [31:0]        stored_keys[$];

   logic [CSR_BITS-1:0] tbl_size = CSR_RESET;
   logic [31:0]         slot_key[MAX_SLOTS];
   logic [15:0]         slot_rec[MAX_SLOTS];
   logic                slot_used[MAX_SLOTS];

   table_req_type  cur_req;
   logic        offering = 1'b0;
   int          send_gap = 0;
   int          resp_stall = 0;
   int          hold_left = 0;
   logic        hold_req = 1'b0;
   logic        no_idle = 1'b0;
   int          error_count = 0;
   longint      cycle_count = 0;

   double_hash_table_insert_find DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic table_outcome_type probe_table(table_req_type r);
      int unsigned       n;
      int unsigned       idx;
      int unsigned       stride;
      int unsigned       i;
      table_outcome_type o;
      n = tbl_size;
      if (n < MIN_SIZE) n = MIN_SIZE;
      if (n > MAX_SLOTS) n = MAX_SLOTS;
      idx = r.key % n;
      stride = 1 + r.key % (n - 2);
      o.status = r.is_find ? ST_NOT_FOUND : ST_FULL;
      o.slot = '0;
      o.rec = '0;
      for (i = 0; i < n; i++) begin
         if (!r.is_find) begin
            if (!slot_used[idx]) begin
               slot_used[idx] = 1'b1;
               slot_key[idx] = r.key;
               slot_rec[idx] = r.rec;
               o.status = ST_INSERTED;
               o.slot = idx[9:0];
               break;
            end
         end else begin
            if (!slot_used[idx]) break;
            if (slot_key[idx] == r.key) begin
               o.status = ST_FOUND;
               o.slot = idx[9:0];
               o.rec = slot_rec[idx];
               break;
            end
         end
         idx += stride;
         if (idx >= n) idx -= n;
      end
      return o;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         offering = 1'b0;
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pending_outcomes.insert(pending_outcomes.size(), probe_table(cur_req));
            offering = 1'b0;
            send_gap = no_idle ? 0 : $urandom_range(0, 4);
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (request_queue.size() > 0) begin
               cur_req = request_queue.pop_front();
               offering = 1'b1;
            end
         end
         req_tvalid <= offering;
         req_tdata <= {cur_req.rec, cur_req.key};
         req_tuser <= cur_req.is_find;
      end
   end

   // result monitor and receiver
   always @(posedge clock) begin
      table_outcome_type want;
      logic              ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outcomes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected word status %0d slot %0d record %0h",
                        $time, rsp_tuser, rsp_tdata[9:0], rsp_tdata[25:10]);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_tuser !== want.status) begin
                  error_count++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_tuser);
               end
               if (rsp_tdata[9:0] !== want.slot) begin
                  error_count++;
                  $display("%0t: slot_index expected %0d actual %0d",
                           $time, want.slot, rsp_tdata[9:0]);
               end
               if (rsp_tdata[25:10] !== want.rec) begin
                  error_count++;
                  $display("%0t: found_record expected %0h actual %0h",
                           $time, want.rec, rsp_tdata[25:10]);
               end
               if (rsp_tdata[31:26] !== '0) begin
                  error_count++;
                  $display("%0t: pad bits expected 0 actual %0h", $time, rsp_tdata[31:26]);
               end
            end
            resp_stall = no_idle ? 0 : $urandom_range(0, 4);
         end
         if (hold_req) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
         end else if (resp_stall > 0) begin
            resp_stall--;
            ready = 1'b0;
         end else begin
            ready = 1'b1;
         end
         rsp_tready <= ready;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic wait_drained();
      while (request_queue.size() > 0 || offering || pending_outcomes.size() > 0)
         @(posedge clock);
   endtask

   task automatic set_table_size(logic [CSR_BITS-1:0] value);
      wait_drained();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      tbl_size = value;
   endtask

   task automatic add_req(logic is_find, logic [31:0] key, logic [15:0] rec);
      table_req_type r;
      r.is_find = is_find;
      r.key = key;
      r.rec = rec;
      request_queue.insert(request_queue.size(), r);
      if (!is_find) stored_keys.insert(stored_keys.size(), key);
   endtask

   task automatic add_random(int count);
      int          pick;
      logic [31:0] key;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         key = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 255)) : $urandom();
         if (pick < 45)
            add_req(REQ_INSERT, key, 16'($urandom()));
         else if (pick < 80 && stored_keys.size() > 0)
            add_req(REQ_FIND, stored_keys[$urandom_range(0, stored_keys.size() - 1)],
                    16'($urandom()));
         else
            add_req(REQ_FIND, key, 16'($urandom()));
      end
   endtask

   initial begin
      int unsigned phase_sizes[20];
      int          k;
      phase_sizes = '{5, 8, 16, 3, 31, 1024, 64, 0, 100, 13,
                      2047, 7, 250, 1, 40, 1024, 2, 12, 512, 9};
      for (k = 0; k < MAX_SLOTS; k++) begin
         slot_used[k] = 1'b0;
         slot_key[k] = '0;
         slot_rec[k] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      set_table_size(11'd1024);
      add_req(REQ_INSERT, 32'h0, 16'h0);
      add_req(REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
      add_req(REQ_FIND, 32'h0, 16'h0);
      add_req(REQ_FIND, 32'hFFFF_FFFF, 16'hFFFF);
      add_req(REQ_FIND, 32'd12345, 16'h0);
      add_req(REQ_INSERT, 32'h0, 16'h1234);
      add_req(REQ_FIND, 32'h0, 16'hFFFF);
      add_req(REQ_INSERT, 32'hA5A5_5A5A, 16'h5A5A);
      add_req(REQ_FIND, 32'hA5A5_5A5A, 16'h0);

      set_table_size(11'd0);
      add_req(REQ_INSERT, 32'd5, 16'd3);
      add_req(REQ_INSERT, 32'd7, 16'd4);
      add_req(REQ_FIND, 32'd9, 16'h0);
      add_req(REQ_FIND, 32'd5, 16'h0);

      set_table_size(11'd12);
      for (k = 0; k < 6; k++)
         add_req(REQ_INSERT, 32'd1, 16'(k + 1));
      add_req(REQ_FIND, 32'hFFFF_FFFF, 16'h0);

      set_table_size(11'd2047);
      add_req(REQ_FIND, 32'hA5A5_5A5A, 16'h0);
      add_req(REQ_FIND, 32'h0, 16'h0);
      add_req(REQ_INSERT, 32'hFFFF_FFFE, 16'h8001);

      for (k = 0; k < 20; k++) begin
         set_table_size(phase_sizes[k][CSR_BITS-1:0]);
         no_idle = (k % 5 == 2);
         if (k == 3) hold_req = 1'b1;
         add_random(51);
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/dhtif_pkg.sv
rtl/dhtif_ram.sv
rtl/dhtif_dp.sv
rtl/dhtif_ctrl.sv
rtl/double_hash_table_insert_find.sv
verif/tb_top.sv
